>>> rtl/arsm_pkg.sv
// Shared types and constants for the axis reduction core.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package arsm_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int COUNT_WIDTH     = 16;
  localparam int TOTAL_WIDTH     = VALUE_WIDTH + COUNT_WIDTH;
  localparam int STEP_WIDTH      = $clog2(TOTAL_WIDTH + 1);
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KIND   = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH = CFG_INDEX_WIDTH'(1);

  typedef enum logic [1:0] {
    KIND_SUM    = 2'd0,
    KIND_MEAN   = 2'd1,
    KIND_MAX    = 2'd2,
    KIND_ARGMAX = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic [COUNT_WIDTH-1:0]         len;
    logic signed [TOTAL_WIDTH-1:0]  total;
    logic signed [VALUE_WIDTH-1:0]  best;
    logic [COUNT_WIDTH-1:0]         best_pos;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage
`default_nettype wire

>>> rtl/axis_reduction_sum_mean_max_argmax_core.sv
// Reduces runs of axis_length signed Q16.16 elements into one sum, mean, max or
// argmax result per run. An element is accepted every cycle while the two-entry
// run queue has room. Sum, max and argmax results are registered in the cycle
// after their record leaves the queue; a mean goes via the 48-step restoring
// divider in the back end; short mean runs throttle input once the queue
// fills. Kind and length are written on the cfg port (index 0 kind, 1 length).
// Top level: config registers, arsm_front, arsm_queue and arsm_back.
`timescale 1ns / 1ps
`default_nettype none
module axis_reduction_sum_mean_max_argmax_core (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         cfg_valid,
  output logic                                              cfg_ready,
  input  wire logic [arsm_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
  input  wire logic [arsm_pkg::COUNT_WIDTH-1:0]             cfg_data,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic signed [arsm_pkg::VALUE_WIDTH-1:0]      in_sample_value,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic signed [arsm_pkg::VALUE_WIDTH-1:0]           out_reduced_value,
  output logic [arsm_pkg::COUNT_WIDTH-1:0]                  out_best_index,
  output logic                                              out_saturated
);

  arsm_pkg::kind_t                   kind_r;
  logic [arsm_pkg::COUNT_WIDTH-1:0]  length_r;
  arsm_pkg::run_t                    push_rec;
  arsm_pkg::run_t                    head_rec;
  arsm_pkg::fifo_status_t            q_stat;
  logic                              push;
  logic                              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= arsm_pkg::KIND_SUM;
      length_r <= arsm_pkg::COUNT_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        arsm_pkg::REG_KIND:   kind_r   <= arsm_pkg::kind_t'(cfg_data[1:0]);
        arsm_pkg::REG_LENGTH: length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  arsm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .kind            (kind_r),
    .axis_length     (length_r),
    .q_stat          (q_stat),
    .push            (push),
    .rec             (push_rec)
  );

  arsm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_rec),
    .pop   (pop),
    .rdata (head_rec),
    .stat  (q_stat)
  );

  arsm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec               (head_rec),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reduced_value (out_reduced_value),
    .out_best_index    (out_best_index),
    .out_saturated     (out_saturated)
  );

endmodule
`default_nettype wire

>>> rtl/arsm_front.sv
// Front end: accumulates total, maximum and its position over each run.
// Emits one run record per completed run; uses arsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arsm_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [arsm_pkg::VALUE_WIDTH-1:0]  in_sample_value,
  input  wire arsm_pkg::kind_t                          kind,
  input  wire logic [arsm_pkg::COUNT_WIDTH-1:0]         axis_length,
  input  wire arsm_pkg::fifo_status_t                   q_stat,
  output logic                                          push,
  output arsm_pkg::run_t                                rec
);

  logic [arsm_pkg::COUNT_WIDTH-1:0]        count_r, count_nxt;
  logic signed [arsm_pkg::TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic signed [arsm_pkg::VALUE_WIDTH-1:0] best_r, best_nxt;
  logic [arsm_pkg::COUNT_WIDTH-1:0]        bpos_r, bpos_nxt;
  logic [arsm_pkg::COUNT_WIDTH-1:0]        len_eff;
  logic                                    accept;
  logic                                    last;
  logic                                    take;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign len_eff  = (axis_length == '0) ? arsm_pkg::COUNT_WIDTH'(1) : axis_length;
  assign last     = ({1'b0, count_r} + (arsm_pkg::COUNT_WIDTH+1)'(1)) >= {1'b0, len_eff};
  assign take     = (count_r == '0) || (in_sample_value > best_r);

  always_comb begin
    best_nxt  = take ? in_sample_value : best_r;
    bpos_nxt  = take ? count_r : bpos_r;
    total_nxt = total_r + arsm_pkg::TOTAL_WIDTH'(in_sample_value);
    count_nxt = count_r + arsm_pkg::COUNT_WIDTH'(1);
  end

  assign push         = accept && last;
  assign rec.kind     = kind;
  assign rec.len      = len_eff;
  assign rec.total    = total_nxt;
  assign rec.best     = best_nxt;
  assign rec.best_pos = bpos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      best_r  <= '0;
      bpos_r  <= '0;
    end else if (accept) begin
      best_r <= best_nxt;
      bpos_r <= bpos_nxt;
      if (last) begin
        count_r <= '0;
        total_r <= '0;
      end else begin
        count_r <= count_nxt;
        total_r <= total_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/arsm_queue.sv
// Two-entry queue of run records between front and back.
// Uses arsm_pkg for the record and status types.
`timescale 1ns / 1ps
`default_nettype none
module arsm_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire arsm_pkg::run_t   wdata,
  input  wire logic             pop,
  output arsm_pkg::run_t        rdata,
  output arsm_pkg::fifo_status_t stat
);

  arsm_pkg::run_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;

  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/arsm_back.sv
// Back end: turns run records into results; mean goes through a
// one-bit-per-cycle restoring divider. Uses arsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arsm_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire arsm_pkg::run_t                      rec,
  input  wire arsm_pkg::fifo_status_t              q_stat,
  output logic                                     pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [arsm_pkg::VALUE_WIDTH-1:0]  out_reduced_value,
  output logic [arsm_pkg::COUNT_WIDTH-1:0]         out_best_index,
  output logic                                     out_saturated
);

  localparam int TW = arsm_pkg::TOTAL_WIDTH;
  localparam int VW = arsm_pkg::VALUE_WIDTH;
  localparam int CW = arsm_pkg::COUNT_WIDTH;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 clipped;
  } clamp_t;

  function automatic clamp_t clamp_value(input logic signed [TW:0] v);
    clamp_t r;
    logic   fits;
    fits      = (&v[TW:VW-1]) || !(|v[TW:VW-1]);
    r.clipped = !fits;
    if (fits) begin
      r.value = v[VW-1:0];
    end else if (v[TW]) begin
      r.value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(VW-1){1'b1}}};
    end
    return r;
  endfunction

  state_t                           state_r;
  logic                             out_valid_r;
  logic signed [VW-1:0]             value_r;
  logic [CW-1:0]                    index_r;
  logic                             sat_r;
  logic [TW-1:0]                    quo_r;
  logic [CW-1:0]                    rem_r;
  logic [CW-1:0]                    div_r;
  logic                             neg_r;
  logic [arsm_pkg::STEP_WIDTH-1:0]  step_r;

  logic                             slot_free;
  logic                             load_out;
  logic [CW:0]                      trial;
  logic                             fit_bit;
  logic [CW:0]                      trial_sub;
  logic signed [TW:0]               quo_signed;
  logic signed [TW:0]               total_wide;
  clamp_t                           mean_clamp;
  clamp_t                           sum_clamp;

  assign slot_free = !out_valid_r || out_ready;
  assign pop = (state_r == ST_IDLE) && !q_stat.empty &&
               ((rec.kind == arsm_pkg::KIND_MEAN) || slot_free);
  assign load_out = ((state_r == ST_IDLE) && pop && (rec.kind != arsm_pkg::KIND_MEAN)) ||
                    ((state_r == ST_DIV) && (step_r == '0) && slot_free);

  always_comb begin
    trial      = {rem_r, quo_r[TW-1]};
    trial_sub  = trial - {1'b0, div_r};
    fit_bit    = (trial >= {1'b0, div_r});
    quo_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    total_wide = {rec.total[TW-1], rec.total};
    mean_clamp = clamp_value(quo_signed);
    sum_clamp  = clamp_value(total_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            if (rec.kind == arsm_pkg::KIND_MEAN) begin
              neg_r   <= rec.total[TW-1];
              quo_r   <= rec.total[TW-1] ? TW'(-rec.total) : TW'(rec.total);
              rem_r   <= '0;
              div_r   <= rec.len;
              step_r  <= arsm_pkg::STEP_WIDTH'(TW);
              state_r <= ST_DIV;
            end else begin
              unique case (rec.kind)
                arsm_pkg::KIND_SUM: begin
                  value_r <= sum_clamp.value;
                  index_r <= '0;
                  sat_r   <= sum_clamp.clipped;
                end
                arsm_pkg::KIND_MAX: begin
                  value_r <= rec.best;
                  index_r <= rec.best_pos;
                  sat_r   <= 1'b0;
                end
                default: begin
                  value_r <= '0;
                  index_r <= rec.best_pos;
                  sat_r   <= 1'b0;
                end
              endcase
            end
          end
        end
        ST_DIV: begin
          if (step_r != '0) begin
            rem_r  <= fit_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
            quo_r  <= {quo_r[TW-2:0], fit_bit};
            step_r <= step_r - arsm_pkg::STEP_WIDTH'(1);
          end else if (slot_free) begin
            value_r     <= mean_clamp.value;
            index_r     <= '0;
            sat_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_value = value_r;
  assign out_best_index    = index_r;
  assign out_saturated     = sat_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("record taken from empty queue");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r != '0))
    else $error("divide by zero length");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (step_r <= arsm_pkg::STEP_WIDTH'(TW)))
    else $error("divider step count out of range");

endmodule
`default_nettype wire

>>> test/reduction_checker.sv
// Checker for the axis reduction core: tracks runs on the cfg and input channels,
// predicts each run's sum, mean, max or argmax and compares every output transaction.
// Depends on arsm_pkg for widths, register indexes and the kind encoding.
`timescale 1ns / 1ps
module reduction_checker
  import arsm_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [COUNT_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] in_sample_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] out_reduced_value,
  input  wire logic [COUNT_WIDTH-1:0]        out_best_index,
  input  wire logic                          out_saturated,
  output int                                 error_count,
  output int                                 pending,
  output int                                 runs_checked,
  output int                                 clipped_runs
);

  localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]        index;
    logic                          clipped;
  } run_result_t;

  run_result_t                   expected_runs[$];
  kind_t                         kind;
  logic [COUNT_WIDTH-1:0]        run_len;
  logic [COUNT_WIDTH-1:0]        position;
  logic [COUNT_WIDTH-1:0]        best_pos;
  logic signed [TOTAL_WIDTH-1:0] total;
  logic signed [VALUE_WIDTH-1:0] best;

  function automatic logic signed [VALUE_WIDTH-1:0] clip_to_q16(input longint acc,
                                                                output logic hit);
    hit = 1'b0;
    if (acc > VALUE_MAX) begin
      hit = 1'b1;
      return VALUE_WIDTH'(VALUE_MAX);
    end
    if (acc < VALUE_MIN) begin
      hit = 1'b1;
      return VALUE_WIDTH'(VALUE_MIN);
    end
    return VALUE_WIDTH'(acc);
  endfunction

  always @(posedge clk) begin : track_runs
    run_result_t            want;
    logic [COUNT_WIDTH:0]   span;
    logic                   unused_hit;
    if (!rst_n) begin
      kind     = KIND_SUM;
      run_len  = 1;
      position = '0;
      total    = '0;
      best     = '0;
      best_pos = '0;
      expected_runs.delete();
      error_count  = 0;
      runs_checked = 0;
      clipped_runs = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KIND) begin
          kind = kind_t'(cfg_data[1:0]);
        end else if (cfg_index == REG_LENGTH) begin
          run_len = cfg_data;
        end
      end

      if (in_valid && in_ready) begin
        if (position == '0 || in_sample_value > best) begin
          best     = in_sample_value;
          best_pos = position;
        end
        total = total + in_sample_value;
        span  = (run_len == '0) ? (COUNT_WIDTH + 1)'(1) : {1'b0, run_len};
        if ({1'b0, position} + 1 < span) begin
          position = position + 1'b1;
        end else begin
          want = '0;
          case (kind)
            KIND_SUM: begin
              want.value = clip_to_q16(longint'(total), want.clipped);
            end
            KIND_MEAN: begin
              want.value = clip_to_q16(longint'(total) / longint'(span), unused_hit);
            end
            KIND_MAX: begin
              want.value = best;
              want.index = best_pos;
            end
            default: begin
              want.index = best_pos;
            end
          endcase
          expected_runs.push_back(want);
          position = '0;
          total    = '0;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected result: reduced_value %0d best_index %0d saturated %0b",
                 out_reduced_value, out_best_index, out_saturated);
          error_count++;
        end else begin
          want = expected_runs.pop_front();
          runs_checked++;
          if (want.clipped) begin
            clipped_runs++;
          end
          if (out_reduced_value !== want.value) begin
            $error("reduced_value: expected %0d, actual %0d",
                   $signed(want.value), out_reduced_value);
            error_count++;
          end
          if (out_best_index !== want.index) begin
            $error("best_index: expected %0d, actual %0d", want.index, out_best_index);
            error_count++;
          end
          if (out_saturated !== want.clipped) begin
            $error("saturated: expected %0b, actual %0b", want.clipped, out_saturated);
            error_count++;
          end
        end
      end
      pending <= expected_runs.size();
    end
  end

endmodule

>>> test/tb_axis_reduction_sum_mean_max_argmax_core.sv
// Testbench top for the axis reduction core: clock, reset, cfg and sample stimulus,
// output back-pressure, a no-progress watchdog and the verdict.
// Depends on arsm_pkg, the core and reduction_checker, which does all checking.
`timescale 1ns / 1ps
module tb_axis_reduction_sum_mean_max_argmax_core;
  import arsm_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_SAMPLES = 800;
  localparam int IDLE_PCT       = 6;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = CFG_INDEX_WIDTH'(3);

  localparam logic signed [VALUE_WIDTH-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_WIDTH-1:0] Q_MIN = 32'sh8000_0000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index;
  logic [COUNT_WIDTH-1:0]        cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] in_sample_value;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [VALUE_WIDTH-1:0] out_reduced_value;
  logic [COUNT_WIDTH-1:0]        out_best_index;
  logic                          out_saturated;

  int fault_count;
  int awaiting;
  int runs_checked;
  int clipped_runs;
  int samples_sent;
  int random_sent;
  int quiet;
  int in_idle_pct;
  int out_idle_pct;
  bit hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  axis_reduction_sum_mean_max_argmax_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reduced_value (out_reduced_value),
    .out_best_index    (out_best_index),
    .out_saturated     (out_saturated)
  );

  reduction_checker check_runs (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reduced_value (out_reduced_value),
    .out_best_index    (out_best_index),
    .out_saturated     (out_saturated),
    .error_count       (fault_count),
    .pending           (awaiting),
    .runs_checked      (runs_checked),
    .clipped_runs      (clipped_runs)
  );

  task automatic push_sample(input logic signed [VALUE_WIDTH-1:0] sample);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= sample;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [COUNT_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input kind_t kind, input logic [COUNT_WIDTH-1:0] len,
                             input bit spare);
    settle();
    write_reg(REG_KIND, COUNT_WIDTH'(kind));
    write_reg(REG_LENGTH, len);
    if (spare) begin
      write_reg(REG_SPARE_LO, COUNT_WIDTH'($urandom));
      write_reg(REG_SPARE_HI, COUNT_WIDTH'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2, 3: return int'($urandom_range(0, 40)) - 20;
      default: return $urandom;
    endcase
  endfunction

  // hold the output side off once, long enough for the core to back up
  initial begin : sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("** axis_reduction_sum_mean_max_argmax_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    kind_t                  kind;
    logic [COUNT_WIDTH-1:0] len;
    int                     count;
    int                     phase;
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    quiet           <= 0;
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    hold_req     = 1'b0;
    samples_sent = 0;
    random_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sum over single-element runs
    push_sample(Q_MAX);
    push_sample(Q_MIN);

    reconfigure(KIND_SUM, 2, 1'b1);
    push_sample(Q_MAX);
    push_sample(Q_MAX);
    push_sample(Q_MIN);
    push_sample(Q_MIN);
    push_sample(-1);
    push_sample(1);

    reconfigure(KIND_MEAN, 2, 1'b0);
    push_sample(Q_MAX);
    push_sample(Q_MAX);
    push_sample(-1);
    push_sample('0);

    reconfigure(KIND_MAX, 4, 1'b0);
    push_sample(Q_MIN);
    push_sample(7);
    push_sample(7);
    push_sample(-1);

    reconfigure(KIND_ARGMAX, 3, 1'b0);
    push_sample(Q_MIN);
    push_sample(Q_MIN);
    push_sample(Q_MIN);

    reconfigure(KIND_MAX, 0, 1'b0);
    push_sample(-5);

    // shorten the run and switch kind while elements are already counted
    reconfigure(KIND_MAX, 10, 1'b0);
    repeat (5) push_sample(Q_MAX);
    reconfigure(KIND_SUM, 3, 1'b0);
    push_sample(Q_MAX);

    phase = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      kind  = kind_t'($urandom_range(0, 3));
      count = $urandom_range(20, 80);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
        7, 8: len = $urandom_range(9, 40);
        default: len = $urandom_range(41, 300);
      endcase
      if (phase == 0) begin
        len = '1;
      end else if (phase == 1) begin
        len = '0;
      end else if (phase == 8) begin
        len = 1;
      end
      if (phase >= 4 && phase <= 6) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      reconfigure(kind, len, $urandom_range(0, 9) == 0);
      if (phase == 8) begin
        hold_req = 1'b1;
      end
      repeat (count) push_sample(pick_sample());
      random_sent += count;
      phase++;
    end

    settle();
    $display("Run covered %0d samples in %0d phases and %0d checked runs (%0d clipped sums),",
             samples_sent, phase, runs_checked, clipped_runs);
    $display("all four kinds, run lengths from 0 to 65535 and a long output stall.");
    if (fault_count == 0) begin
      $display("** axis_reduction_sum_mean_max_argmax_core: PASSED **");
    end else begin
      $display("** axis_reduction_sum_mean_max_argmax_core: FAILED **");
    end
    $finish;
  end

endmodule
